[hdl/pgr_pkg.sv]
// Shared constants for the five-point Poisson residual engine.
// Used by poisson_grid_residual; no dependencies.
package pgr_pkg;

    localparam int MAX_DIM_DEFAULT = 64;
    localparam int DATA_W          = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int DIM_REG_W       = 7;
    localparam int MEAN_W          = 63;

    localparam logic [1:0] CMD_WRITE    = 2'd0;
    localparam logic [1:0] CMD_READ     = 2'd1;
    localparam logic [1:0] CMD_BOUNDARY = 2'd2;
    localparam logic [1:0] CMD_RESIDUAL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DX_SQ   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DY_SQ   = 3'd3;

    localparam logic [DIM_REG_W-1:0] GRID_DIM_RESET = 7'd64;
    localparam logic [DATA_W-1:0]    INV_SQ_RESET   = 32'h0001_0000;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic [MEAN_W-1:0] MEAN_SAT = {MEAN_W{1'b1}};

endpackage

[hdl/poisson_grid_residual.sv]
// Five-point Poisson residual engine: pressure and source grids in block RAM,
// boundary copy and mean squared residual by a sequencer. Depends on pgr_pkg.
//
//  channel   ports                                   direction
//  input     s_valid/s_ready, s_command..s_source_in  in
//  result    m_valid/m_ready, m_pressure_out..status  out
//  config    cfg_wr_en, cfg_index, cfg_wr_data        in
//
// Reads pass through the registered RAM read. The residual makes five reads per
// cell on the single pressure RAM port plus five passes through the shared
// 32x32 multiplier, then a bit-serial 64-step divide for the mean.
// Reset clears control and config; RAM contents are undefined until written.
// A new item is taken only when idle and the result register is free.
module poisson_grid_residual #(
    parameter int MAX_DIM = pgr_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pgr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pgr_pkg::DATA_W-1:0]          cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_command,
    input  logic [5:0]                          s_col,
    input  logic [5:0]                          s_row,
    input  logic signed [pgr_pkg::DATA_W-1:0]   s_pressure_in,
    input  logic signed [pgr_pkg::DATA_W-1:0]   s_source_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pgr_pkg::DATA_W-1:0]   m_pressure_out,
    output logic [pgr_pkg::MEAN_W-1:0]          m_mean_residual,
    output logic                                m_status
);
    import pgr_pkg::*;

    localparam int IW    = $clog2(MAX_DIM);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int VW    = 2 * DW;

    localparam logic [3:0] PH_RD_C  = 4'd0;
    localparam logic [3:0] PH_RD_L  = 4'd1;
    localparam logic [3:0] PH_RD_R  = 4'd2;
    localparam logic [3:0] PH_RD_D  = 4'd3;
    localparam logic [3:0] PH_RD_U  = 4'd4;
    localparam logic [3:0] PH_DIFF  = 4'd5;
    localparam logic [3:0] PH_XHI   = 4'd6;
    localparam logic [3:0] PH_XLO   = 4'd7;
    localparam logic [3:0] PH_YHI   = 4'd8;
    localparam logic [3:0] PH_YLO   = 4'd9;
    localparam logic [3:0] PH_ABS   = 4'd10;
    localparam logic [3:0] PH_SQ    = 4'd11;
    localparam logic [3:0] PH_ACC   = 4'd12;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_BND  = 5'b00100,
        ST_RES  = 5'b01000,
        ST_DIV  = 5'b10000
    } state_t;

    function automatic logic [AW-1:0] addr_of(input logic [DW-1:0] r, input logic [DW-1:0] c);
        addr_of = {IW'(r), IW'(c)};
    endfunction

    state_t state_reg, state_next;

    logic [DIM_REG_W-1:0] gw_reg, gh_reg;
    logic [DATA_W-1:0]    kx_reg, ky_reg;

    logic [1:0]    sub_reg, sub_next;
    logic          bcol_reg, bcol_next;
    logic [DW-1:0] idx_reg, idx_next;
    logic [DW-1:0] rr_reg, rr_next;
    logic [3:0]    ph_reg, ph_next;
    logic [5:0]    bit_reg, bit_next;
    logic [63:0]   sum_reg, sum_next;

    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] pout_reg;
    logic [MEAN_W-1:0]        mean_reg;
    logic                     status_reg;

    logic                     out_load;
    logic signed [DATA_W-1:0] out_p;
    logic [MEAN_W-1:0]        out_mean;
    logic                     out_status;

    logic [DATA_W-1:0] p_mem [DEPTH];
    logic [DATA_W-1:0] src_mem [DEPTH];
    logic [DATA_W-1:0] p_q_reg, src_q_reg;
    logic [AW-1:0]     p_raddr, p_waddr;
    logic [DATA_W-1:0] p_wdata;
    logic              p_we, src_we;

    logic [DW-1:0] w_eff, h_eff, w_m1, w_m2, h_m1, h_m2;
    logic          oob, accept;

    logic signed [DATA_W-1:0] pc_reg, pl_reg, pr_reg, pd_reg, src_reg;
    logic [33:0]  xmag_reg, ymag_reg;
    logic         xneg_reg, yneg_reg;
    logic [49:0]  q_reg;
    logic signed [63:0] r_reg;
    logic [63:0]  rmag_reg, sq_reg, quot_reg, quot_new;
    logic [VW-1:0] div_reg, rem_reg, rem_new;
    logic [VW:0]  rem_sh;

    logic signed [33:0] pl_x, pr_x, pd_x, pu_x, pc2_x, dxx, dyy;
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  prod;
    logic [49:0]  qsum;
    logic [63:0]  term_mag, sterm;
    logic [64:0]  sum_add;
    logic [63:0]  sum_sat;

    // grid size clamped to [3, MAX_DIM]
    always_comb begin
        if (gw_reg < 7'd3) begin
            w_eff = DW'(3);
        end else if (32'(gw_reg) > 32'(MAX_DIM)) begin
            w_eff = DW'(MAX_DIM);
        end else begin
            w_eff = DW'(gw_reg);
        end
        if (gh_reg < 7'd3) begin
            h_eff = DW'(3);
        end else if (32'(gh_reg) > 32'(MAX_DIM)) begin
            h_eff = DW'(MAX_DIM);
        end else begin
            h_eff = DW'(gh_reg);
        end
    end

    assign w_m1 = w_eff - DW'(1);
    assign w_m2 = w_eff - DW'(2);
    assign h_m1 = h_eff - DW'(1);
    assign h_m2 = h_eff - DW'(2);

    assign oob    = (32'(s_col) >= 32'(w_eff)) || (32'(s_row) >= 32'(h_eff));
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept = s_valid && s_ready;

    // arithmetic
    assign pl_x  = {{2{pl_reg[31]}}, pl_reg};
    assign pr_x  = {{2{pr_reg[31]}}, pr_reg};
    assign pd_x  = {{2{pd_reg[31]}}, pd_reg};
    assign pu_x  = {{2{p_q_reg[31]}}, p_q_reg};
    assign pc2_x = {pc_reg[31], pc_reg, 1'b0};
    assign dxx   = pl_x + pr_x - pc2_x;
    assign dyy   = pd_x + pu_x - pc2_x;

    always_comb begin
        case (ph_reg)
            PH_XHI:  begin mul_a = 32'(xmag_reg[33:16]); mul_b = kx_reg; end
            PH_XLO:  begin mul_a = 32'(xmag_reg[15:0]);  mul_b = kx_reg; end
            PH_YHI:  begin mul_a = 32'(ymag_reg[33:16]); mul_b = ky_reg; end
            PH_YLO:  begin mul_a = 32'(ymag_reg[15:0]);  mul_b = ky_reg; end
            PH_SQ:   begin mul_a = rmag_reg[31:0];       mul_b = rmag_reg[31:0]; end
            default: begin mul_a = '0;                   mul_b = '0; end
        endcase
    end

    assign prod     = 64'(mul_a) * 64'(mul_b);
    assign qsum     = q_reg + 50'(prod[47:16]);
    assign term_mag = 64'(qsum);
    // scaled term rounds toward zero: negate magnitude for a negative difference
    assign sterm    = ((ph_reg == PH_XLO) ? xneg_reg : yneg_reg) ? (~term_mag + 64'd1)
                                                               : term_mag;
    assign sum_add  = {1'b0, sum_reg} + {1'b0, sq_reg};
    assign sum_sat  = sum_add[64] ? {64{1'b1}} : sum_add[63:0];

    assign rem_sh   = {rem_reg, quot_reg[63]};
    always_comb begin
        if (rem_sh >= {1'b0, div_reg}) begin
            rem_new  = VW'(rem_sh - {1'b0, div_reg});
            quot_new = {quot_reg[62:0], 1'b1};
        end else begin
            rem_new  = rem_sh[VW-1:0];
            quot_new = {quot_reg[62:0], 1'b0};
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        sub_next   = sub_reg;
        bcol_next  = bcol_reg;
        idx_next   = idx_reg;
        rr_next    = rr_reg;
        ph_next    = ph_reg;
        bit_next   = bit_reg;
        sum_next   = sum_reg;
        p_raddr    = addr_of(DW'(s_row), DW'(s_col));
        p_waddr    = addr_of(DW'(s_row), DW'(s_col));
        p_wdata    = s_pressure_in;
        p_we       = 1'b0;
        src_we     = 1'b0;
        out_load   = 1'b0;
        out_p      = '0;
        out_mean   = '0;
        out_status = STATUS_OK;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_command)
                        CMD_WRITE: begin
                            out_load = 1'b1;
                            if (oob) begin
                                out_status = STATUS_RANGE;
                            end else begin
                                p_we   = 1'b1;
                                src_we = 1'b1;
                            end
                        end
                        CMD_READ: begin
                            if (oob) begin
                                out_load   = 1'b1;
                                out_status = STATUS_RANGE;
                            end else begin
                                state_next = ST_READ;
                            end
                        end
                        CMD_BOUNDARY: begin
                            state_next = ST_BND;
                            bcol_next  = 1'b0;
                            sub_next   = 2'd0;
                            idx_next   = DW'(1);
                        end
                        default: begin
                            state_next = ST_RES;
                            ph_next    = PH_RD_C;
                            rr_next    = DW'(1);
                            idx_next   = DW'(1);
                            sum_next   = '0;
                        end
                    endcase
                end
            end

            ST_READ: begin
                out_load   = 1'b1;
                out_p      = p_q_reg;
                state_next = ST_IDLE;
            end

            ST_BND: begin
                // rows first over interior columns, then columns over all rows
                p_wdata = p_q_reg;
                if (!bcol_reg) begin
                    case (sub_reg)
                        2'd0: begin
                            p_raddr  = addr_of(DW'(1), idx_reg);
                            sub_next = 2'd1;
                        end
                        2'd1: begin
                            p_we     = 1'b1;
                            p_waddr  = addr_of(DW'(0), idx_reg);
                            p_raddr  = addr_of(h_m2, idx_reg);
                            sub_next = 2'd2;
                        end
                        default: begin
                            p_we     = 1'b1;
                            p_waddr  = addr_of(h_m1, idx_reg);
                            sub_next = 2'd0;
                            if (idx_reg == w_m2) begin
                                bcol_next = 1'b1;
                                idx_next  = '0;
                            end else begin
                                idx_next = idx_reg + DW'(1);
                            end
                        end
                    endcase
                end else begin
                    case (sub_reg)
                        2'd0: begin
                            p_raddr  = addr_of(idx_reg, DW'(1));
                            sub_next = 2'd1;
                        end
                        2'd1: begin
                            p_we     = 1'b1;
                            p_waddr  = addr_of(idx_reg, DW'(0));
                            p_raddr  = addr_of(idx_reg, w_m2);
                            sub_next = 2'd2;
                        end
                        default: begin
                            p_we     = 1'b1;
                            p_waddr  = addr_of(idx_reg, w_m1);
                            sub_next = 2'd0;
                            if (idx_reg == h_m1) begin
                                out_load   = 1'b1;
                                state_next = ST_IDLE;
                            end else begin
                                idx_next = idx_reg + DW'(1);
                            end
                        end
                    endcase
                end
            end

            ST_RES: begin
                case (ph_reg)
                    PH_RD_C: p_raddr = addr_of(rr_reg, idx_reg);
                    PH_RD_L: p_raddr = addr_of(rr_reg, idx_reg - DW'(1));
                    PH_RD_R: p_raddr = addr_of(rr_reg, idx_reg + DW'(1));
                    PH_RD_D: p_raddr = addr_of(rr_reg - DW'(1), idx_reg);
                    PH_RD_U: p_raddr = addr_of(rr_reg + DW'(1), idx_reg);
                    default: p_raddr = addr_of(rr_reg, idx_reg);
                endcase
                if (ph_reg == PH_ACC) begin
                    sum_next = sum_sat;
                    ph_next  = PH_RD_C;
                    if (idx_reg == w_m2) begin
                        idx_next = DW'(1);
                        if (rr_reg == h_m2) begin
                            state_next = ST_DIV;
                            bit_next   = '0;
                        end else begin
                            rr_next = rr_reg + DW'(1);
                        end
                    end else begin
                        idx_next = idx_reg + DW'(1);
                    end
                end else begin
                    ph_next = ph_reg + 4'd1;
                end
            end

            ST_DIV: begin
                bit_next = bit_reg + 6'd1;
                if (bit_reg == 6'd63) begin
                    out_load   = 1'b1;
                    out_mean   = quot_new[63] ? MEAN_SAT : quot_new[62:0];
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sub_reg     <= '0;
            bcol_reg    <= 1'b0;
            idx_reg     <= '0;
            rr_reg      <= '0;
            ph_reg      <= PH_RD_C;
            bit_reg     <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
            gw_reg      <= GRID_DIM_RESET;
            gh_reg      <= GRID_DIM_RESET;
            kx_reg      <= INV_SQ_RESET;
            ky_reg      <= INV_SQ_RESET;
        end else begin
            state_reg   <= state_next;
            sub_reg     <= sub_next;
            bcol_reg    <= bcol_next;
            idx_reg     <= idx_next;
            rr_reg      <= rr_next;
            ph_reg      <= ph_next;
            bit_reg     <= bit_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_GRID_WIDTH:  gw_reg <= cfg_wr_data[DIM_REG_W-1:0];
                    REG_GRID_HEIGHT: gh_reg <= cfg_wr_data[DIM_REG_W-1:0];
                    REG_INV_DX_SQ:   kx_reg <= cfg_wr_data;
                    REG_INV_DY_SQ:   ky_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    // grid RAMs, registered read
    always_ff @(posedge aclk) begin
        if (p_we) begin
            p_mem[p_waddr] <= p_wdata;
        end
        p_q_reg <= p_mem[p_raddr];
    end

    always_ff @(posedge aclk) begin
        if (src_we) begin
            src_mem[p_waddr] <= s_source_in;
        end
        src_q_reg <= src_mem[p_raddr];
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (out_load) begin
            pout_reg   <= out_p;
            mean_reg   <= out_mean;
            status_reg <= out_status;
        end
        if (accept && s_command == CMD_RESIDUAL) begin
            div_reg <= VW'(w_m2) * VW'(h_m2);
        end
        if (state_reg == ST_RES) begin
            case (ph_reg)
                PH_RD_L: begin
                    pc_reg  <= p_q_reg;
                    src_reg <= src_q_reg;
                end
                PH_RD_R: pl_reg <= p_q_reg;
                PH_RD_D: pr_reg <= p_q_reg;
                PH_RD_U: pd_reg <= p_q_reg;
                PH_DIFF: begin
                    xneg_reg <= dxx[33];
                    yneg_reg <= dyy[33];
                    xmag_reg <= dxx[33] ? 34'(-dxx) : 34'(dxx);
                    ymag_reg <= dyy[33] ? 34'(-dyy) : 34'(dyy);
                end
                PH_XHI, PH_YHI: q_reg <= prod[49:0];
                PH_XLO: r_reg <= {{32{src_reg[31]}}, src_reg} - $signed(sterm);
                PH_YLO: r_reg <= r_reg - $signed(sterm);
                PH_ABS: rmag_reg <= r_reg[63] ? 64'(-r_reg) : 64'(r_reg);
                PH_SQ:  sq_reg <= (rmag_reg[63:32] != 32'd0) ? {64{1'b1}} : prod;
                PH_ACC: begin
                    quot_reg <= sum_sat;
                    rem_reg  <= '0;
                end
                default: ;
            endcase
        end
        if (state_reg == ST_DIV) begin
            rem_reg  <= rem_new;
            quot_reg <= quot_new;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pressure_out  = pout_reg;
    assign m_mean_residual = mean_reg;
    assign m_status        = status_reg;

    a_accept_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (!m_valid || m_ready))
        else $error("input transfer while result register is occupied");

    a_write_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == CMD_WRITE) |=> m_valid)
        else $error("write transfer produced no result");

    a_range_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_RANGE) |->
        (m_pressure_out == 32'sd0 && m_mean_residual == '0))
        else $error("range error result carries data");

endmodule
